// File: rtl/sgs_pkg.sv
// shared types and constants of the savitzky-golay point smoother
package sgs_pkg;

  // defaults of the top-level parameters
  localparam int MAX_HALF_WINDOW_DEF = 3;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COEF_BITS_DEF       = 16;

  // kernel shape: seven taps, minus3 .. plus3, center at index 3
  localparam int NUM_TAPS   = 7;
  localparam int TAP_CENTER = 3;
  localparam int HALF_BITS  = 2;

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_HALF_WINDOW = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_COEF_BASE   = 3'd1;

  // reset values of the configuration registers
  localparam logic [HALF_BITS-1:0] RESET_HALF_WINDOW = 2'd3;
  localparam int RESET_COEF [NUM_TAPS] = '{-1560, 2341, 4681, 5461, 4681, 2341, -1560};

  // depth of the queues between the parts
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // control part of one command from the front to the back
  typedef struct packed {
    logic                 first;  // opens a sequence, fill the window
    logic                 eos;    // closes a sequence, flush the tail
    logic [HALF_BITS-1:0] skip;   // leading steps that give no result
  } cmd_ctl_t;

  localparam int CMD_CTL_BITS = $bits(cmd_ctl_t);

  // one filter evaluation handed to the fir pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } emit_t;

endpackage

// File: rtl/savitzky_golay_smoother_core.sv
// top level of the savitzky-golay point smoother
//
// Smooths a stream of 2-D points (x and y separately) with a
// kernel of 2*h+1 taps, h the half-width register; sequence edges replicate
// the end samples.
// Input side is a queue: a word (sample_x, sample_y, end_of_sequence) is
// taken on a clock edge with push high and full low. Result side is a
// queue too: the oldest result sits on smooth_x, smooth_y, last_of_sequence
// while empty is low and leaves on an edge with pop high.
// Throughput: one point per cycle while the back part has room; a word
// with end_of_sequence holds the back part for one step per flush position,
// while the front keeps taking words into a 4-deep command queue.
// Path: a taken word passes the command queue, window update, products,
// pair sums and total registers, then the result queue, to the output ports.
// Reset: half width 3 and the default kernel, no sequence open, queues
// empty. The configuration port writes one register per cycle; write it
// only while no word is in flight.
// Stall: while pop is low the 8-deep result queue fills; the back part stops
// once results in flight would overflow it, then the command queue fills
// and full goes high. Nothing is dropped.
module savitzky_golay_smoother_core #(
  parameter int MAX_HALF_WINDOW = sgs_pkg::MAX_HALF_WINDOW_DEF,
  parameter int SAMPLE_BITS     = sgs_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS       = sgs_pkg::COEF_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input points
  input  logic                                push,
  output logic                                full,
  input  logic signed [SAMPLE_BITS-1:0]       sample_x,
  input  logic signed [SAMPLE_BITS-1:0]       sample_y,
  input  logic                                end_of_sequence,
  // smoothed points
  output logic                                empty,
  input  logic                                pop,
  output logic signed [SAMPLE_BITS-1:0]       smooth_x,
  output logic signed [SAMPLE_BITS-1:0]       smooth_y,
  output logic                                last_of_sequence,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [sgs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [COEF_BITS-1:0]                cfg_data
);

  import sgs_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int KEEP      = (WIN_DEPTH < NUM_TAPS) ? WIN_DEPTH : NUM_TAPS;
  localparam int H_LIM     = (MAX_HALF_WINDOW < TAP_CENTER) ? MAX_HALF_WINDOW : TAP_CENTER;
  localparam int CMD_W     = CMD_CTL_BITS + 2 * SAMPLE_BITS;
  localparam int RES_W     = 2 * SAMPLE_BITS + 1;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  logic [HALF_BITS-1:0]          half_len;
  logic [HALF_BITS-1:0]          half;
  logic signed [COEF_BITS-1:0]   coef [NUM_TAPS];

  logic                          cmd_push;
  logic [CMD_W-1:0]              cmd_wdata;
  logic                          cmd_full;
  logic                          cmd_pop;
  logic [CMD_W-1:0]              cmd_rdata;
  logic                          cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  cmd_ctl_t                      cmd_ctl;
  logic signed [SAMPLE_BITS-1:0] cmd_x;
  logic signed [SAMPLE_BITS-1:0] cmd_y;

  logic signed [SAMPLE_BITS-1:0] win_x [KEEP];
  logic signed [SAMPLE_BITS-1:0] win_y [KEEP];
  emit_t                         emit;
  logic                          issue;
  logic                          room;

  logic                          res_valid;
  logic                          res_last;
  logic signed [SAMPLE_BITS-1:0] res_x;
  logic signed [SAMPLE_BITS-1:0] res_y;
  logic [RES_W-1:0]              out_rdata;
  logic                          out_full;
  logic [OCW-1:0]                out_count;
  logic [OCW-1:0]                in_flight;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_len <= RESET_HALF_WINDOW;
      for (int i = 0; i < NUM_TAPS; i++) begin
        coef[i] <= COEF_BITS'(RESET_COEF[i]);
      end
    end else if (cfg_we) begin
      if (cfg_addr == CFG_HALF_WINDOW) begin
        half_len <= cfg_data[HALF_BITS-1:0];
      end else begin
        coef[cfg_addr - CFG_COEF_BASE] <= cfg_data;
      end
    end
  end

  // half window in use, clamped to what the window holds
  assign half = (half_len > HALF_BITS'(H_LIM)) ? HALF_BITS'(H_LIM) : half_len;

  // front part
  sgs_front #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .sample_x        (sample_x),
    .sample_y        (sample_y),
    .end_of_sequence (end_of_sequence),
    .half            (half),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd_word        (cmd_wdata)
  );

  assign full = cmd_full;

  // command queue between front and back
  sgs_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  assign {cmd_ctl, cmd_x, cmd_y} = cmd_rdata;

  // result queue room, counting runs still in the fir pipeline
  assign room = ((OCW+1)'(out_count) + (OCW+1)'(in_flight)) < (OCW+1)'(OUT_DEPTH)
                && (cmd_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (issue && !res_valid) begin
      in_flight <= in_flight + 1'b1;
    end else if (!issue && res_valid) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  // back part
  sgs_back #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .KEEP            (KEEP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd_ctl   (cmd_ctl),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .half      (half),
    .room      (room),
    .cmd_pop   (cmd_pop),
    .issue     (issue),
    .win_x     (win_x),
    .win_y     (win_y),
    .emit      (emit)
  );

  // filter pipeline
  sgs_fir #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .KEEP        (KEEP)
  ) u_fir (
    .clk       (clk),
    .rst       (rst),
    .win_x     (win_x),
    .win_y     (win_y),
    .coef      (coef),
    .half      (half),
    .emit      (emit),
    .res_valid (res_valid),
    .res_last  (res_last),
    .res_x     (res_x),
    .res_y     (res_y)
  );

  // result queue
  sgs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata ({res_last, res_x, res_y}),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign {last_of_sequence, smooth_x, smooth_y} = out_rdata;

endmodule

// File: rtl/sgs_fifo.sv
// small register fifo with first-word fall-through read
module sgs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sgs_front.sv
// front part: accepts points, tracks the open sequence and builds commands
module sgs_front #(
  parameter int MAX_HALF_WINDOW = sgs_pkg::MAX_HALF_WINDOW_DEF,
  parameter int SAMPLE_BITS     = sgs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            push,
  input  logic signed [SAMPLE_BITS-1:0]                   sample_x,
  input  logic signed [SAMPLE_BITS-1:0]                   sample_y,
  input  logic                                            end_of_sequence,
  input  logic [sgs_pkg::HALF_BITS-1:0]                   half,
  input  logic                                            cmd_full,
  output logic                                            cmd_push,
  output logic [sgs_pkg::CMD_CTL_BITS+2*SAMPLE_BITS-1:0]  cmd_word
);

  import sgs_pkg::*;

  localparam int CAP   = MAX_HALF_WINDOW + 1;
  localparam int CNT_W = $clog2(MAX_HALF_WINDOW + 2);

  logic [CNT_W-1:0] seen_count;
  logic [CNT_W-1:0] seen_count_next;
  logic [CNT_W-1:0] half_ext;
  cmd_ctl_t         ctl;

  assign cmd_push = push && !cmd_full;
  assign half_ext = CNT_W'(half);

  // classify the word: window fill, flush, and how many steps stay silent
  always_comb begin
    ctl.first = (seen_count == '0);
    ctl.eos   = end_of_sequence;
    if (seen_count >= half_ext) begin
      ctl.skip = '0;
    end else begin
      ctl.skip = HALF_BITS'(half_ext - seen_count);
    end
    if (end_of_sequence) begin
      seen_count_next = '0;
    end else if (seen_count < CNT_W'(CAP)) begin
      seen_count_next = seen_count + 1'b1;
    end else begin
      seen_count_next = seen_count;
    end
  end

  assign cmd_word = {ctl, sample_x, sample_y};

  // samples seen in the open sequence, capped at MAX_HALF_WINDOW + 1, zero when none is open
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (cmd_push) begin
      seen_count <= seen_count_next;
    end
  end

endmodule

// File: rtl/sgs_back.sv
// back part: steps through commands, keeps the sample window, issues filter runs
module sgs_back #(
  parameter int SAMPLE_BITS     = sgs_pkg::SAMPLE_BITS_DEF,
  parameter int KEEP            = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  input  sgs_pkg::cmd_ctl_t                   cmd_ctl,
  input  logic signed [SAMPLE_BITS-1:0]       cmd_x,
  input  logic signed [SAMPLE_BITS-1:0]       cmd_y,
  input  logic [sgs_pkg::HALF_BITS-1:0]       half,
  input  logic                                room,
  output logic                                cmd_pop,
  output logic                                issue,
  output logic signed [SAMPLE_BITS-1:0]       win_x [KEEP],
  output logic signed [SAMPLE_BITS-1:0]       win_y [KEEP],
  output sgs_pkg::emit_t                      emit
);

  import sgs_pkg::*;

  logic [HALF_BITS-1:0] step;
  logic                 act;
  logic                 done;
  logic                 fill;
  emit_t                emit_next;

  // one step per cycle while a command waits and the output side has room
  always_comb begin
    act             = cmd_valid && room;
    fill            = cmd_ctl.first && (step == '0);
    done            = !cmd_ctl.eos || (step == half);
    emit_next.valid = act && (step >= cmd_ctl.skip);
    emit_next.last  = cmd_ctl.eos && (step == half);
  end

  assign cmd_pop = act && done;
  assign issue   = emit_next.valid;

  // flush step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      emit <= '0;
    end else begin
      emit <= emit_next;
      if (act) begin
        step <= done ? '0 : step + 1'b1;
      end
    end
  end

  // sample window, newest at the top index
  always_ff @(posedge clk) begin
    if (act) begin
      for (int i = 0; i < KEEP - 1; i++) begin
        if (fill) begin
          win_x[i] <= cmd_x;
          win_y[i] <= cmd_y;
        end else begin
          win_x[i] <= win_x[i+1];
          win_y[i] <= win_y[i+1];
        end
      end
      win_x[KEEP-1] <= cmd_x;
      win_y[KEEP-1] <= cmd_y;
    end
  end

endmodule

// File: rtl/sgs_fir.sv
// fir pipeline: tap products, pair sums, total, then rounding and saturation
module sgs_fir #(
  parameter int SAMPLE_BITS = sgs_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sgs_pkg::COEF_BITS_DEF,
  parameter int KEEP        = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [SAMPLE_BITS-1:0]       win_x [KEEP],
  input  logic signed [SAMPLE_BITS-1:0]       win_y [KEEP],
  input  logic signed [COEF_BITS-1:0]         coef [sgs_pkg::NUM_TAPS],
  input  logic [sgs_pkg::HALF_BITS-1:0]       half,
  input  sgs_pkg::emit_t                      emit,
  output logic                                res_valid,
  output logic                                res_last,
  output logic signed [SAMPLE_BITS-1:0]       res_x,
  output logic signed [SAMPLE_BITS-1:0]       res_y
);

  import sgs_pkg::*;

  localparam int IDX_W  = $clog2(KEEP);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int SUM_W  = PROD_W + 3;
  localparam int FRAC   = COEF_BITS - 2;
  localparam int NPAIR  = (NUM_TAPS + 1) / 2;
  localparam logic signed [SUM_W:0] RND_HALF = (SUM_W+1)'(1) <<< (FRAC - 1);
  localparam logic signed [SUM_W:0] SAT_MAX =
    (SUM_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W:0] SAT_MIN = -SAT_MAX - (SUM_W+1)'(1);

  logic signed [SAMPLE_BITS-1:0] tap_x [NUM_TAPS];
  logic signed [SAMPLE_BITS-1:0] tap_y [NUM_TAPS];
  logic signed [PROD_W-1:0]      prod_x [NUM_TAPS];
  logic signed [PROD_W-1:0]      prod_y [NUM_TAPS];
  logic signed [SUM_W-1:0]       pair_x [NPAIR];
  logic signed [SUM_W-1:0]       pair_y [NPAIR];
  logic signed [SUM_W-1:0]       sum_x;
  logic signed [SUM_W-1:0]       sum_y;
  logic signed [SUM_W:0]         rnd_x;
  logic signed [SUM_W:0]         rnd_y;
  emit_t                         v1;
  emit_t                         v2;
  emit_t                         v3;

  // pick the window sample under each used tap, zero under the others
  always_comb begin
    for (int c = 0; c < NUM_TAPS; c++) begin
      if (c >= TAP_CENTER - int'(half) && c <= TAP_CENTER + int'(half)) begin
        tap_x[c] = win_x[IDX_W'(KEEP - 1 - TAP_CENTER - int'(half) + c)];
        tap_y[c] = win_y[IDX_W'(KEEP - 1 - TAP_CENTER - int'(half) + c)];
      end else begin
        tap_x[c] = '0;
        tap_y[c] = '0;
      end
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_TAPS; c++) begin
      prod_x[c] <= tap_x[c] * coef[c];
      prod_y[c] <= tap_y[c] * coef[c];
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    for (int p = 0; p < NPAIR; p++) begin
      if (2 * p + 1 < NUM_TAPS) begin
        pair_x[p] <= SUM_W'(prod_x[2*p]) + SUM_W'(prod_x[2*p+1]);
        pair_y[p] <= SUM_W'(prod_y[2*p]) + SUM_W'(prod_y[2*p+1]);
      end else begin
        pair_x[p] <= SUM_W'(prod_x[2*p]);
        pair_y[p] <= SUM_W'(prod_y[2*p]);
      end
    end
  end

  // stage 3: total
  always_ff @(posedge clk) begin
    sum_x <= (pair_x[0] + pair_x[1]) + (pair_x[2] + pair_x[3]);
    sum_y <= (pair_y[0] + pair_y[1]) + (pair_y[2] + pair_y[3]);
  end

  // valid and last travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
      v2 <= '0;
      v3 <= '0;
    end else begin
      v1 <= emit;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // round to nearest, ties up, then clamp to the sample range
  always_comb begin
    rnd_x = ((SUM_W+1)'(sum_x) + RND_HALF) >>> FRAC;
    rnd_y = ((SUM_W+1)'(sum_y) + RND_HALF) >>> FRAC;
    if (rnd_x > SAT_MAX) begin
      res_x = SAMPLE_BITS'(SAT_MAX);
    end else if (rnd_x < SAT_MIN) begin
      res_x = SAMPLE_BITS'(SAT_MIN);
    end else begin
      res_x = SAMPLE_BITS'(rnd_x);
    end
    if (rnd_y > SAT_MAX) begin
      res_y = SAMPLE_BITS'(SAT_MAX);
    end else if (rnd_y < SAT_MIN) begin
      res_y = SAMPLE_BITS'(SAT_MIN);
    end else begin
      res_y = SAMPLE_BITS'(rnd_y);
    end
  end

  assign res_valid = v3.valid;
  assign res_last  = v3.last;

endmodule

// File: bench/testbench.sv
// testbench for the savitzky-golay point smoother core
`timescale 1ns / 100ps

module testbench;
  import sgs_pkg::*;

  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int CW          = COEF_BITS_DEF;
  localparam int MAX_HALF    = MAX_HALF_WINDOW_DEF;
  localparam int SEEN_CAP    = MAX_HALF + 1;
  localparam int FRAC        = CW - 2;
  localparam int DRAIN_WAIT  = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 62;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic signed [CW-1:0] coef_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    logic    last;
  } point_t;

  // block ports
  logic                     clk;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  sample_t                  sample_x = '0;
  sample_t                  sample_y = '0;
  logic                     end_of_sequence = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  sample_t                  smooth_x;
  sample_t                  smooth_y;
  logic                     last_of_sequence;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CW-1:0]            cfg_data = '0;

  // predicted block state
  sample_t               x_hist [NUM_TAPS];
  sample_t               y_hist [NUM_TAPS];
  int                    seen;
  logic [HALF_BITS-1:0]  half_win;
  coef_t                 kernel [NUM_TAPS];

  point_t expected_points [$];
  int     failures = 0;
  int     quiet_cycles = 0;
  int     stall_left = 0;
  bit     steady = 1'b0;

  savitzky_golay_smoother_core DUT (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .sample_x         (sample_x),
    .sample_y         (sample_y),
    .end_of_sequence  (end_of_sequence),
    .empty            (empty),
    .pop              (pop),
    .smooth_x         (smooth_x),
    .smooth_y         (smooth_y),
    .last_of_sequence (last_of_sequence),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // one axis of the kernel over the newest 2h+1 samples, rounded and saturated
  function automatic sample_t smooth_axis(bit use_y, int h);
    longint acc;
    longint tap_val;
    longint smax;
    longint smin;
    int     wi;
    smax = (longint'(1) <<< (SW - 1)) - 1;
    smin = -smax - 1;
    acc = 0;
    for (int t = 0; t <= 2 * h; t++) begin
      wi = NUM_TAPS - 1 - 2 * h + t;
      tap_val = use_y ? longint'(y_hist[wi]) : longint'(x_hist[wi]);
      acc += tap_val * longint'(kernel[TAP_CENTER - h + t]);
    end
    acc += longint'(1) <<< (FRAC - 1);
    acc = acc >>> FRAC;
    if (acc > smax) acc = smax;
    if (acc < smin) acc = smin;
    return sample_t'(acc);
  endfunction

  function automatic void shift_in(sample_t x, sample_t y);
    for (int i = 0; i < NUM_TAPS - 1; i++) begin
      x_hist[i] = x_hist[i + 1];
      y_hist[i] = y_hist[i + 1];
    end
    x_hist[NUM_TAPS - 1] = x;
    y_hist[NUM_TAPS - 1] = y;
  endfunction

  function automatic void queue_point(int h, logic last);
    point_t p;
    p.x = smooth_axis(1'b0, h);
    p.y = smooth_axis(1'b1, h);
    p.last = last;
    expected_points = {expected_points, p};
  endfunction

  // update the window for one taken word and queue the points it releases
  function automatic void predict_point(sample_t x, sample_t y, logic eos);
    int h;
    int m;
    h = int'(half_win);
    if (h > MAX_HALF) h = MAX_HALF;
    if (seen == 0) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        x_hist[i] = x;
        y_hist[i] = y;
      end
    end else begin
      shift_in(x, y);
    end
    m = seen;
    if (seen < SEEN_CAP) seen++;
    if (!eos) begin
      if (m >= h) queue_point(h, 1'b0);
    end else begin
      // flush the tail, padding with the last sample
      for (int s = 0; s <= h; s++) begin
        if (s > 0) shift_in(x, y);
        if (m + s >= h) queue_point(h, s == h);
      end
      seen = 0;
    end
  endfunction

  // offer one word, with random gaps, and predict once it is taken
  task automatic send_word(sample_t x, sample_t y, logic eos);
    while (!steady && $urandom_range(99) < 19) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    end_of_sequence <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_point(x, y, eos);
  endtask

  // stop sending until every predicted point has come out
  task automatic hold_until_drained(int extra);
    push <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_BITS-1:0] addr, logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == CFG_HALF_WINDOW) half_win = data[HALF_BITS-1:0];
    else kernel[int'(addr) - int'(CFG_COEF_BASE)] = coef_t'(data);
  endtask

  task automatic load_kernel(input int taps [NUM_TAPS]);
    for (int k = 0; k < NUM_TAPS; k++)
      cfg_write(CFG_COEF_BASE + CFG_ADDR_BITS'(k), CW'(taps[k]));
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return sample_t'(32767);
      1: return sample_t'(-32768);
      2: return sample_t'($urandom_range(512)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // reset kernel: extremes of both axes, saturation, a one-point sequence
  task automatic test_default_kernel();
    send_word(32767, -32768, 1'b0);
    send_word(-32768, 32767, 1'b0);
    send_word(0, -1, 1'b0);
    send_word(-1, 0, 1'b0);
    send_word(16'sh5555, 16'shAAAA, 1'b1);
    repeat (3) send_word(32767, -32768, 1'b0);
    send_word(32767, -32768, 1'b1);
    send_word(1234, -4321, 1'b1);
    hold_until_drained(DRAIN_WAIT);
  endtask

  // single tap: pass-through scaling, overflow and the rounding tie
  task automatic test_single_tap();
    cfg_write(CFG_HALF_WINDOW, '0);
    cfg_write(CFG_COEF_BASE + CFG_ADDR_BITS'(TAP_CENTER), CW'(-32768));
    send_word(-32768, 32767, 1'b0);
    send_word(32767, -32768, 1'b1);
    hold_until_drained(DRAIN_WAIT);
    cfg_write(CFG_COEF_BASE + CFG_ADDR_BITS'(TAP_CENTER), CW'(8192));
    send_word(1, -1, 1'b1);
    hold_until_drained(DRAIN_WAIT);
    cfg_write(CFG_COEF_BASE + CFG_ADDR_BITS'(TAP_CENTER), CW'(32767));
    send_word(-32768, 32767, 1'b1);
    hold_until_drained(DRAIN_WAIT);
  endtask

  // three and five taps with alternating extreme coefficients
  task automatic test_narrow_windows();
    load_kernel('{32767, -32768, 32767, -32768, 32767, -32768, 32767});
    cfg_write(CFG_HALF_WINDOW, CW'(1));
    send_word(32767, -32768, 1'b0);
    send_word(-32768, 32767, 1'b0);
    send_word(32767, 0, 1'b1);
    hold_until_drained(DRAIN_WAIT);
    cfg_write(CFG_HALF_WINDOW, CW'(2));
    send_word(-1, 1, 1'b1);
    send_word(100, -100, 1'b0);
    send_word(-200, 200, 1'b1);
    hold_until_drained(DRAIN_WAIT);
  endtask

  // registers change while a sequence is open and apply to held samples
  task automatic test_reconfig_mid_sequence();
    load_kernel(RESET_COEF);
    cfg_write(CFG_HALF_WINDOW, CW'(3));
    send_word(500, -500, 1'b0);
    send_word(-700, 700, 1'b0);
    hold_until_drained(DRAIN_WAIT);
    cfg_write(CFG_HALF_WINDOW, CW'(1));
    cfg_write(CFG_COEF_BASE + CFG_ADDR_BITS'(TAP_CENTER - 1), CW'(8192));
    send_word(900, 900, 1'b0);
    send_word(-900, -900, 1'b0);
    send_word(32767, -32768, 1'b1);
    hold_until_drained(DRAIN_WAIT);
  endtask

  // random window and kernel, junk in the unused upper bits of the half width
  task automatic randomize_config();
    logic [CW-1:0] word;
    int            mode;
    mode = $urandom_range(3);
    word = CW'($urandom);
    word[HALF_BITS-1:0] = HALF_BITS'($urandom_range(3));
    cfg_write(CFG_HALF_WINDOW, word);
    for (int k = 0; k < NUM_TAPS; k++) begin
      case (mode)
        0: word = CW'(RESET_COEF[k]);
        1: word = CW'($urandom_range(8192)) - CW'(4096);
        default: word = CW'($urandom);
      endcase
      cfg_write(CFG_COEF_BASE + CFG_ADDR_BITS'(k), word);
    end
  endtask

  // random sequences under random settings; one phase runs without random gaps or output stalls
  task automatic test_random_streams();
    int sent;
    int len;
    bit paused;
    for (int phase = 0; phase < PHASES; phase++) begin
      hold_until_drained(DRAIN_WAIT);
      steady = (phase == 3);
      randomize_config();
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(8, 1);
        for (int i = 0; i < len && sent < PHASE_WORDS; i++) begin
          send_word(random_sample(), random_sample(), i == len - 1);
          sent++;
        end
        // let the output side catch up once per phase
        if (!paused && sent > PHASE_WORDS / 2) begin
          hold_until_drained(0);
          paused = 1'b1;
        end
      end
    end
    steady = 1'b0;
  endtask

  // output side: random pops with occasional long stalls, always popping in the steady phase
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(299) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(40, 20);
    end else begin
      pop <= steady || ($urandom_range(99) >= 19);
    end
  end

  // compare each popped word with the oldest prediction
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && pop && !empty) begin
      if (expected_points.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected word: x=%0d y=%0d last=%0b",
                   smooth_x, smooth_y, last_of_sequence);
      end else begin
        want = expected_points.pop_front();
        if (smooth_x !== want.x || smooth_y !== want.y || last_of_sequence !== want.last) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.x, want.y, want.last, smooth_x, smooth_y, last_of_sequence);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    half_win = RESET_HALF_WINDOW;
    for (int i = 0; i < NUM_TAPS; i++) begin
      kernel[i] = coef_t'(RESET_COEF[i]);
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    seen = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_kernel();
    test_single_tap();
    test_narrow_windows();
    test_reconfig_mid_sequence();
    test_random_streams();
    hold_until_drained(2 * DRAIN_WAIT);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: savitzky_golay_smoother_core.f
rtl/sgs_pkg.sv
rtl/sgs_fifo.sv
rtl/sgs_front.sv
rtl/sgs_back.sv
rtl/sgs_fir.sv
rtl/savitzky_golay_smoother_core.sv
bench/testbench.sv
